[design/mwe_pkg.sv]
`timescale 1ns / 1ps

package mwe_pkg;

    localparam int MEM_WORDS_DEFAULT = 1024;

    localparam logic [7:0] BUSY_TICKS_RESET = 8'd100;

    localparam logic [1:0] REG_DEVICE_PRESENT = 2'd0;
    localparam logic [1:0] REG_DEVICE_SIZE    = 2'd1;
    localparam logic [1:0] REG_BYTE_MODE      = 2'd2;
    localparam logic [1:0] REG_BUSY_TICKS     = 2'd3;

    typedef struct packed {
        logic       device_present;
        logic [2:0] device_size;
        logic       byte_mode;
        logic [7:0] busy_ticks;
    } cfg_t;

    typedef struct packed {
        logic rd;
        logic wr_lo;
        logic wr_hi;
    } mem_ctl_t;

    typedef struct packed {
        logic programming;
        logic dirty;
        logic data_out;
    } res_t;

endpackage

[design/microwire_eeprom_slave.sv]
`timescale 1ns / 1ps

// Microwire serial EEPROM slave in the 93C46..93C86 style. Each input
// transaction is a pin sample or a busy tick and yields exactly one output
// transaction with the data line level, the dirty flag and the programming
// flag. A transaction is taken every clock as long as the two-entry output
// queue has room and the store sweep is done; its result is written into that
// queue on acceptance. The word store sits in two byte-wide synchronous
// memories, so a byte write needs no read-modify-write, and read data comes
// out of the memory in the cycle after the READ command. After reset the
// store is swept to all ones, one word per cycle, which holds s_tready low
// until every word is written; configuration writes are taken during that sweep.

module microwire_eeprom_slave
    import mwe_pkg::*;
#(
    parameter int MEMORY_WORDS = MEM_WORDS_DEFAULT,
    localparam int AW = $clog2(MEMORY_WORDS)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pin_counter[7:0], data_in_enable, data_in_level
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // data_out, dirty, programming
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t          cfg_reg;
    logic          accept;
    logic          store_ready;
    logic          q_space;
    res_t          result;
    mem_ctl_t      mem_ctl;
    logic [AW-1:0] mem_idx;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_present <= 1'b0;
            cfg_reg.device_size    <= 3'd0;
            cfg_reg.byte_mode      <= 1'b0;
            cfg_reg.busy_ticks     <= BUSY_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEVICE_PRESENT: cfg_reg.device_present <= cfg_data[0];
                REG_DEVICE_SIZE:    cfg_reg.device_size    <= cfg_data[2:0];
                REG_BYTE_MODE:      cfg_reg.byte_mode      <= cfg_data[0];
                REG_BUSY_TICKS:     cfg_reg.busy_ticks     <= cfg_data;
            endcase
        end
    end

    assign s_tready = store_ready && q_space;
    assign accept   = s_tvalid && s_tready;

    mwe_ctrl #(
        .MEMORY_WORDS(MEMORY_WORDS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .item_valid     (accept),
        .req_type       (s_tuser),
        .pin_counter    (s_tdata[7:0]),
        .data_in_enable (s_tdata[8]),
        .data_in_level  (s_tdata[9]),
        .result         (result),
        .mem_ctl        (mem_ctl),
        .mem_idx        (mem_idx),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    mwe_store #(
        .MEMORY_WORDS(MEMORY_WORDS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mem_ctl),
        .idx   (mem_idx),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .ready (store_ready)
    );

    mwe_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .space     (q_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[design/mwe_store.sv]
`timescale 1ns / 1ps

module mwe_store
    import mwe_pkg::*;
#(
    parameter int MEMORY_WORDS = MEM_WORDS_DEFAULT,
    localparam int AW = $clog2(MEMORY_WORDS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mem_ctl_t      ctl,
    input  logic [AW-1:0] idx,
    input  logic [15:0]   wdata,
    output logic [15:0]   rdata,
    output logic          ready
);

    localparam logic [AW-1:0] LAST_IDX = AW'(MEMORY_WORDS - 1);

    logic [7:0]    lo_mem [MEMORY_WORDS];
    logic [7:0]    hi_mem [MEMORY_WORDS];
    logic [15:0]   rdata_reg;
    logic [AW-1:0] clr_idx_reg;
    logic          clr_busy_reg;

    // After reset every word is swept to all ones before traffic is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + AW'(1);
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            lo_mem[clr_idx_reg] <= 8'hFF;
            hi_mem[clr_idx_reg] <= 8'hFF;
        end
        else
        begin
            if (ctl.wr_lo)
            begin
                lo_mem[idx] <= wdata[7:0];
            end
            if (ctl.wr_hi)
            begin
                hi_mem[idx] <= wdata[15:8];
            end
            if (ctl.rd)
            begin
                rdata_reg <= {hi_mem[idx], lo_mem[idx]};
            end
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

[design/mwe_ctrl.sv]
`timescale 1ns / 1ps

module mwe_ctrl
    import mwe_pkg::*;
#(
    parameter int MEMORY_WORDS = MEM_WORDS_DEFAULT,
    localparam int AW = $clog2(MEMORY_WORDS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          item_valid,
    input  logic          req_type,
    input  logic [7:0]    pin_counter,
    input  logic          data_in_enable,
    input  logic          data_in_level,
    output res_t          result,
    output mem_ctl_t      mem_ctl,
    output logic [AW-1:0] mem_idx,
    output logic [15:0]   mem_wdata,
    input  logic [15:0]   mem_rdata
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_DATA,
        PH_WAIT
    } phase_t;

    localparam logic [10:0] WORDS_LIMIT = 11'(MEMORY_WORDS);

    phase_t      phase_reg, phase_next;
    logic [16:0] shift_in_reg, shift_in_next;
    logic [10:0] cell_address_reg, cell_address_next;
    logic [15:0] read_shift_reg, read_shift_next;
    logic        out_level_reg, out_level_next;
    logic        write_disabled_reg, write_disabled_next;
    logic        dirty_reg, dirty_next;
    logic        busy_reg, busy_next;
    logic [7:0]  busy_count_reg, busy_count_next;
    logic        last_select_reg, last_select_next;
    logic        last_clock_reg, last_clock_next;
    logic        rd_pend_reg, rd_pend_next;
    logic        rd_hi_reg, rd_hi_next;
    logic        rd_oob_reg, rd_oob_next;

    logic        cs;
    logic        sclk;
    logic        di;
    logic [3:0]  ab;
    logic [15:0] rd_value;
    logic [15:0] rs_cur;

    assign cs   = pin_counter[7];
    assign sclk = pin_counter[1];
    assign di   = data_in_enable & data_in_level;
    assign ab   = ((cfg.device_size <= 3'd4) ? (4'd6 + {1'b0, cfg.device_size}) : 4'd6)
                  + {3'b000, cfg.byte_mode};

    // Last cycle's read: memory word or byte, or ones when out of range.
    always_comb
    begin
        if (rd_oob_reg)
        begin
            rd_value = cfg.byte_mode ? 16'h00FF : 16'hFFFF;
        end
        else if (cfg.byte_mode)
        begin
            rd_value = rd_hi_reg ? {8'h00, mem_rdata[15:8]} : {8'h00, mem_rdata[7:0]};
        end
        else
        begin
            rd_value = mem_rdata;
        end
    end

    assign rs_cur = rd_pend_reg ? rd_value : read_shift_reg;

    always_comb
    begin
        logic [16:0] sh;
        logic [1:0]  op;
        logic [1:0]  ext;
        logic [10:0] ca;
        logic [10:0] acc_addr;
        logic [10:0] widx;
        logic        in_range;
        logic        rd_req;
        logic        wr_req;
        logic        erase;
        logic [7:0]  cnt_inc;

        phase_next          = phase_reg;
        shift_in_next       = shift_in_reg;
        cell_address_next   = cell_address_reg;
        read_shift_next     = rs_cur;
        out_level_next      = out_level_reg;
        write_disabled_next = write_disabled_reg;
        dirty_next          = dirty_reg;
        busy_next           = busy_reg;
        busy_count_next     = busy_count_reg;
        last_select_next    = last_select_reg;
        last_clock_next     = last_clock_reg;
        rd_pend_next        = 1'b0;
        rd_hi_next          = rd_hi_reg;
        rd_oob_next         = rd_oob_reg;

        sh       = '0;
        op       = '0;
        ext      = '0;
        ca       = '0;
        acc_addr = cell_address_reg;
        rd_req   = 1'b0;
        wr_req   = 1'b0;
        erase    = 1'b0;
        cnt_inc  = busy_count_reg + 8'd1;

        if (item_valid && cfg.device_present)
        begin
            if (req_type)
            begin
                if (busy_reg && (busy_count_reg < cfg.busy_ticks))
                begin
                    busy_count_next = cnt_inc;
                    if (cnt_inc >= cfg.busy_ticks)
                    begin
                        out_level_next = 1'b1;
                        busy_next      = 1'b0;
                    end
                end
            end
            else
            begin
                if (cs != last_select_reg)
                begin
                    phase_next    = PH_IDLE;
                    shift_in_next = '0;
                end
                last_select_next = cs;
                last_clock_next  = sclk;

                if (cs && sclk && !last_clock_reg)
                begin
                    if (phase_next == PH_IDLE)
                    begin
                        if (di)
                        begin
                            shift_in_next = 17'd1;
                            phase_next    = PH_ADDR;
                        end
                    end
                    else
                    begin
                        sh            = {shift_in_next[15:0], di};
                        shift_in_next = sh;
                        unique case (phase_next)
                            PH_ADDR:
                            begin
                                if (sh[5'(ab) + 5'd2])
                                begin
                                    op  = 2'(sh >> ab);
                                    ca  = 11'(sh & ((17'd1 << ab) - 17'd1));
                                    ext = 2'(sh >> (ab - 4'd2));
                                    cell_address_next = ca;
                                    acc_addr          = ca;
                                    unique case (op)
                                        2'b10:
                                        begin
                                            rd_req         = 1'b1;
                                            out_level_next = 1'b0;
                                            busy_next      = 1'b0;
                                            phase_next     = PH_WAIT;
                                        end
                                        2'b01:
                                        begin
                                            shift_in_next = 17'd1;
                                            phase_next    = PH_DATA;
                                        end
                                        2'b00:
                                        begin
                                            if (ext == 2'b00)
                                            begin
                                                write_disabled_next = 1'b1;
                                            end
                                            else if (ext == 2'b11)
                                            begin
                                                write_disabled_next = 1'b0;
                                            end
                                            phase_next = PH_IDLE;
                                        end
                                        2'b11:
                                        begin
                                            wr_req          = !write_disabled_reg;
                                            erase           = 1'b1;
                                            busy_count_next = '0;
                                            busy_next       = 1'b1;
                                            out_level_next  = 1'b0;
                                            phase_next      = PH_WAIT;
                                        end
                                    endcase
                                end
                            end
                            PH_DATA:
                            begin
                                if (cfg.byte_mode ? sh[8] : sh[16])
                                begin
                                    wr_req          = !write_disabled_reg;
                                    busy_count_next = '0;
                                    busy_next       = 1'b1;
                                    out_level_next  = 1'b0;
                                    phase_next      = PH_WAIT;
                                end
                            end
                            PH_WAIT:
                            begin
                                if (!busy_reg)
                                begin
                                    out_level_next  = cfg.byte_mode ? rs_cur[7] : rs_cur[15];
                                    read_shift_next = {rs_cur[14:0], 1'b0};
                                end
                            end
                            PH_IDLE:
                            begin
                            end
                        endcase
                    end
                end
            end
        end

        widx     = cfg.byte_mode ? {1'b0, acc_addr[10:1]} : acc_addr;
        in_range = (widx < WORDS_LIMIT);

        mem_idx     = widx[AW-1:0];
        mem_ctl.rd  = rd_req && in_range;
        mem_ctl.wr_lo = wr_req && in_range && (!cfg.byte_mode || !acc_addr[0]);
        mem_ctl.wr_hi = wr_req && in_range && (!cfg.byte_mode || acc_addr[0]);
        if (erase)
        begin
            mem_wdata = 16'hFFFF;
        end
        else
        begin
            mem_wdata = cfg.byte_mode ? {sh[7:0], sh[7:0]} : sh[15:0];
        end

        if (wr_req && in_range)
        begin
            dirty_next = 1'b1;
        end
        if (rd_req)
        begin
            rd_pend_next = 1'b1;
            rd_hi_next   = acc_addr[0];
            rd_oob_next  = !in_range;
        end

        result.data_out    = out_level_next;
        result.dirty       = dirty_next;
        result.programming = busy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            shift_in_reg       <= '0;
            cell_address_reg   <= '0;
            read_shift_reg     <= '0;
            out_level_reg      <= 1'b1;
            write_disabled_reg <= 1'b1;
            dirty_reg          <= 1'b0;
            busy_reg           <= 1'b0;
            busy_count_reg     <= BUSY_TICKS_RESET;
            last_select_reg    <= 1'b0;
            last_clock_reg     <= 1'b0;
            rd_pend_reg        <= 1'b0;
            rd_hi_reg          <= 1'b0;
            rd_oob_reg         <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            shift_in_reg       <= shift_in_next;
            cell_address_reg   <= cell_address_next;
            read_shift_reg     <= read_shift_next;
            out_level_reg      <= out_level_next;
            write_disabled_reg <= write_disabled_next;
            dirty_reg          <= dirty_next;
            busy_reg           <= busy_next;
            busy_count_reg     <= busy_count_next;
            last_select_reg    <= last_select_next;
            last_clock_reg     <= last_clock_next;
            rd_pend_reg        <= rd_pend_next;
            rd_hi_reg          <= rd_hi_next;
            rd_oob_reg         <= rd_oob_next;
        end
    end

endmodule

[design/mwe_outq.sv]
`timescale 1ns / 1ps

module mwe_outq
    import mwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  res_t       push_data,
    output logic       space,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    res_t       q0_reg;
    res_t       q1_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign space    = (count_reg != 2'd2);
    assign m_tdata  = {5'b00000, q0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                q0_reg <= push_data;
            end
            else
            begin
                q0_reg <= q1_reg;
                q1_reg <= push_data;
            end
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                q0_reg <= push_data;
            end
            else
            begin
                q1_reg <= push_data;
            end
        end
    end

endmodule
